### rtl/core/cwbs_pkg.sv
`timescale 1ns / 1ps

package cwbs_pkg;

    localparam int MAX_READ_LEN = 256;
    localparam int MASK_AW      = $clog2(MAX_READ_LEN);
    localparam int FILL_W       = MASK_AW + 1;
    localparam int RUN_W        = 16;
    localparam int DATA_W       = 32;
    localparam int SYM_W        = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // request types
    localparam logic [1:0] REQ_HEADER = 2'd0;
    localparam logic [1:0] REQ_CIGAR  = 2'd1;
    localparam logic [1:0] REQ_BASE   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_INDENT = 2'd0;
    localparam logic [1:0] KIND_BASE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'd1;

    // cigar characters
    localparam logic [SYM_W-1:0] CH_M    = 8'h4D;
    localparam logic [SYM_W-1:0] CH_I    = 8'h49;
    localparam logic [SYM_W-1:0] CH_S    = 8'h53;
    localparam logic [SYM_W-1:0] CH_D    = 8'h44;
    localparam logic [SYM_W-1:0] CH_H    = 8'h48;
    localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] value;
        logic              selected;
        logic              eol;
    } res_t;

    typedef struct packed {
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] last;
    } window_t;

endpackage

### rtl/core/cwbs_in_if.sv
`timescale 1ns / 1ps

interface cwbs_in_if;
    import cwbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  symbol;
    logic [DATA_W-1:0] read_position;
    logic              last_base;

    modport source (
        output valid, req_type, symbol, read_position, last_base,
        input  ready
    );

    modport sink (
        input  valid, req_type, symbol, read_position, last_base,
        output ready
    );
endinterface

### rtl/core/cwbs_out_if.sv
`timescale 1ns / 1ps

interface cwbs_out_if;
    import cwbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        out_kind;
    logic [DATA_W-1:0] out_value;
    logic              selected;
    logic              end_of_line;

    modport source (
        output valid, out_kind, out_value, selected, end_of_line,
        input  ready
    );

    modport sink (
        input  valid, out_kind, out_value, selected, end_of_line,
        output ready
    );
endinterface

### rtl/core/cwbs_cfg_if.sv
`timescale 1ns / 1ps

interface cwbs_cfg_if;
    import cwbs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/cwbs_mask_ram.sv
`timescale 1ns / 1ps

module cwbs_mask_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [cwbs_pkg::MASK_AW-1:0] waddr,
    input  logic                        wdata,
    input  logic                        re,
    input  logic [cwbs_pkg::MASK_AW-1:0] raddr,
    output logic                        rdata
);
    import cwbs_pkg::*;

    logic mem [MAX_READ_LEN];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/cwbs_cfg_regs.sv
`timescale 1ns / 1ps

module cwbs_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    cwbs_cfg_if.sink          cfg,
    output cwbs_pkg::window_t win
);
    import cwbs_pkg::*;

    window_t win_reg;

    assign cfg.ready = 1'b1;
    assign win       = win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.first <= '0;
            win_reg.last  <= '1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_START: win_reg.first <= cfg.data;
                REG_WINDOW_END:   win_reg.last  <= cfg.data;
                default:          ;
            endcase
        end
    end

endmodule

### rtl/core/cwbs_ctrl.sv
`timescale 1ns / 1ps

module cwbs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    cwbs_in_if.sink                      item,
    input  cwbs_pkg::window_t            win,
    output cwbs_pkg::res_t               res,
    output logic                         res_valid,
    input  logic                         res_pop,
    output logic                         mem_we,
    output logic [cwbs_pkg::MASK_AW-1:0] mem_waddr,
    output logic                         mem_wdata,
    output logic                         mem_re,
    output logic [cwbs_pkg::MASK_AW-1:0] mem_raddr,
    input  logic                         mem_rdata
);
    import cwbs_pkg::*;

    localparam int PROD_W = RUN_W + 4;
    localparam int SUM_W  = DATA_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_BASE_RD
    } state_t;

    state_t              state_reg,    state_next;
    logic [FILL_W-1:0]   fill_reg,     fill_next;
    logic [RUN_W-1:0]    run_reg,      run_next;
    logic [FILL_W-1:0]   base_idx_reg, base_idx_next;
    logic [DATA_W-1:0]   start_reg,    start_next;
    logic                failed_reg,   failed_next;
    logic [FILL_W-1:0]   mark_cnt_reg, mark_cnt_next;
    logic                mark_bit_reg, mark_bit_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg,      res_next;
    logic                pend_ok_reg,  pend_ok_next;
    logic [SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                pend_eol_reg, pend_eol_next;

    logic                accept;
    logic                is_digit;
    logic [3:0]          digit;
    logic [PROD_W-1:0]   prod;
    logic [FILL_W-1:0]   avail;
    logic [FILL_W-1:0]   run_cnt;
    logic [SUM_W-1:0]    pos;
    logic                in_window;
    logic                base_sel;

    assign item.ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept     = item.valid && item.ready;
    assign res        = res_reg;
    assign res_valid  = res_valid_reg;

    assign is_digit = item.symbol inside {[CH_ZERO:CH_NINE]};
    assign digit    = 4'(item.symbol - CH_ZERO);
    assign prod     = PROD_W'(run_reg) * PROD_W'(10) + PROD_W'(digit);

    // run length clipped to what is left of the mask
    assign avail   = FILL_W'(MAX_READ_LEN) - fill_reg;
    assign run_cnt = (run_reg > RUN_W'(avail)) ? avail : run_reg[FILL_W-1:0];

    assign pos       = SUM_W'(start_reg) + SUM_W'(base_idx_reg);
    assign in_window = (pos >= SUM_W'(win.first)) && (pos <= SUM_W'(win.last));
    assign base_sel  = pend_ok_reg && mem_rdata;

    assign mem_we    = (state_reg == ST_MARK);
    assign mem_waddr = fill_reg[MASK_AW-1:0];
    assign mem_wdata = mark_bit_reg;
    assign mem_re    = accept && (item.req_type == REQ_BASE);
    assign mem_raddr = base_idx_reg[MASK_AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        run_next       = run_reg;
        base_idx_next  = base_idx_reg;
        start_next     = start_reg;
        failed_next    = failed_reg;
        mark_cnt_next  = mark_cnt_reg;
        mark_bit_next  = mark_bit_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        pend_ok_next   = pend_ok_reg;
        pend_sym_next  = pend_sym_reg;
        pend_eol_next  = pend_eol_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.req_type)
                        REQ_HEADER:
                        begin
                            // entries at or past fill_reg read as unaligned,
                            // so resetting the fill count clears the mask
                            fill_next      = '0;
                            run_next       = '0;
                            base_idx_next  = '0;
                            failed_next    = 1'b0;
                            start_next     = item.read_position;
                            res_valid_next = 1'b1;
                            res_next.kind  = KIND_INDENT;
                            res_next.value = (item.read_position > win.first) ?
                                             item.read_position - win.first : '0;
                            res_next.selected = 1'b0;
                            res_next.eol      = 1'b0;
                        end
                        REQ_CIGAR:
                        begin
                            if (!failed_reg)
                            begin
                                if (is_digit)
                                begin
                                    run_next = (prod > PROD_W'(RUN_MAX)) ?
                                               RUN_MAX : prod[RUN_W-1:0];
                                end
                                else
                                begin
                                    run_next = '0;
                                    case (item.symbol)
                                        CH_M, CH_I, CH_S:
                                        begin
                                            mark_bit_next = (item.symbol != CH_S);
                                            mark_cnt_next = run_cnt;
                                            if (run_cnt != '0)
                                            begin
                                                state_next = ST_MARK;
                                            end
                                        end
                                        CH_D, CH_H: ;
                                        default:
                                        begin
                                            failed_next       = 1'b1;
                                            res_valid_next    = 1'b1;
                                            res_next.kind     = KIND_ERROR;
                                            res_next.value    = DATA_W'(item.symbol);
                                            res_next.selected = 1'b0;
                                            res_next.eol      = 1'b0;
                                        end
                                    endcase
                                end
                            end
                        end
                        REQ_BASE:
                        begin
                            pend_sym_next = item.symbol;
                            pend_eol_next = item.last_base;
                            pend_ok_next  = 1'b0;
                            if (base_idx_reg < FILL_W'(MAX_READ_LEN))
                            begin
                                pend_ok_next  = (base_idx_reg < fill_reg) && in_window;
                                base_idx_next = base_idx_reg + FILL_W'(1);
                            end
                            state_next = ST_BASE_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MARK:
            begin
                // one mask entry per cycle
                fill_next     = fill_reg + FILL_W'(1);
                mark_cnt_next = mark_cnt_reg - FILL_W'(1);
                if (mark_cnt_reg == FILL_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BASE_RD:
            begin
                res_valid_next    = 1'b1;
                res_next.kind     = KIND_BASE;
                res_next.value    = base_sel ? DATA_W'(pend_sym_reg) : '0;
                res_next.selected = base_sel;
                res_next.eol      = pend_eol_reg;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            run_reg       <= '0;
            base_idx_reg  <= '0;
            start_reg     <= '0;
            failed_reg    <= 1'b0;
            mark_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            run_reg       <= run_next;
            base_idx_reg  <= base_idx_next;
            start_reg     <= start_next;
            failed_reg    <= failed_next;
            mark_cnt_reg  <= mark_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mark_bit_reg <= mark_bit_next;
        res_reg      <= res_next;
        pend_ok_reg  <= pend_ok_next;
        pend_sym_reg <= pend_sym_next;
        pend_eol_reg <= pend_eol_next;
    end

`ifndef NO_ASSERTIONS
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK |-> fill_reg < FILL_W'(MAX_READ_LEN))
        else $error("mask write past end of read");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("mask read and write in the same cycle");

    a_base_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BASE_RD |=> res_valid_reg && res_reg.kind == KIND_BASE)
        else $error("base read produced no result");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_READ_LEN) && base_idx_reg <= FILL_W'(MAX_READ_LEN))
        else $error("fill or base index out of range");

    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.req_type == REQ_CIGAR && failed_reg |=> !res_valid_reg)
        else $error("result after parse failure");
`endif

endmodule

### rtl/core/cwbs_out_stage.sv
`timescale 1ns / 1ps

module cwbs_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  cwbs_pkg::res_t res,
    input  logic           res_valid,
    output logic           res_pop,
    cwbs_out_if.source     result
);
    import cwbs_pkg::*;

    logic out_valid_reg;
    res_t out_data_reg;

    // refill whenever the register is empty or being drained
    assign res_pop = res_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_pop)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_kind    = out_data_reg.kind;
    assign result.out_value   = out_data_reg.value;
    assign result.selected    = out_data_reg.selected;
    assign result.end_of_line = out_data_reg.eol;

endmodule

### rtl/core/cigar_window_base_selector_core.sv
`timescale 1ns / 1ps
// Aligned base extraction against a reference window.
// Channels: item (header, cigar character or base), result (indent, base slot
// or parse error) and cfg (index 0 window_start, index 1 window_end). A
// transaction completes on any edge where valid and ready are both high.
// A header returns the indent; cigar digits and operators return nothing,
// except one error for the first bad character of a read; each base returns
// one base slot. Results leave in item order through a result register.
// A cigar digit, D or H is handled on acceptance. M, I or S then writes
// min(run, positions left) aligned-mask entries, one write per cycle on the
// RAM write port. A base waits on the registered mask RAM read before its
// result is built; each result passes the controller's result register and
// then the output register.
// The mask needs no clearing pass: entries at or past the fill count read as
// unaligned. Reset returns the window to 0..0xFFFFFFFF and empties the result
// path. While result.ready is low, one further result is held internally and
// item.ready then drops until the result register drains.
module cigar_window_base_selector_core (
    input  logic   clk,
    input  logic   rst_n,
    cwbs_in_if.sink     item,
    cwbs_out_if.source  result,
    cwbs_cfg_if.sink    cfg
);
    import cwbs_pkg::*;

    window_t             win;
    res_t                res;
    logic                res_valid;
    logic                res_pop;
    logic                mem_we;
    logic [MASK_AW-1:0]  mem_waddr;
    logic                mem_wdata;
    logic                mem_re;
    logic [MASK_AW-1:0]  mem_raddr;
    logic                mem_rdata;

    cwbs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .win   (win)
    );

    cwbs_mask_ram u_mask_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cwbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .win       (win),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (res_pop),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    cwbs_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (res_pop),
        .result    (result)
    );

endmodule
